// ===== hdl/dmawa_pkg.sv =====
// Shared types, constants and saturation helpers for the dual moving-average
// window alarm. No dependencies; every other file imports this package.
package dmawa_pkg;

   localparam int WINDOW_LENGTH  = 10;

   // Largest sample magnitude either lane can hold (humidity full scale).
   localparam int SAMPLE_MAX_MAG = 10000;

   localparam int TOTAL_W = $clog2(WINDOW_LENGTH * SAMPLE_MAX_MAG + 1) + 1;
   localparam int MAG_W   = TOTAL_W - 1;
   localparam int SLOT_W  = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;

   // Divide by the window length as multiply by a rounded-up reciprocal.
   // Exact while mag * (RECIP * WINDOW_LENGTH - 2**SHIFT) < 2**SHIFT.
   localparam int SHIFT   = MAG_W + $clog2(WINDOW_LENGTH);
   localparam int RECIP   = ((1 << SHIFT) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
   localparam int RECIP_W = SHIFT + 1;
   localparam int PROD_W  = MAG_W + RECIP_W;

   localparam int TEMP_MIN = -4000;
   localparam int TEMP_MAX = 8500;
   localparam int HUM_MAX  = 10000;

   localparam int TEMP_LOW_RESET  = 2200;
   localparam int TEMP_HIGH_RESET = 2600;
   localparam int HUM_LOW_RESET   = 3000;
   localparam int HUM_HIGH_RESET  = 6000;

   localparam int ADDR_W = 4;

   localparam logic [1:0] REG_TEMP_LOW  = 2'd0;
   localparam logic [1:0] REG_TEMP_HIGH = 2'd1;
   localparam logic [1:0] REG_HUM_LOW   = 2'd2;
   localparam logic [1:0] REG_HUM_HIGH  = 2'd3;

   typedef logic signed [14:0]         sample_type;
   typedef logic        [13:0]         hum_type;
   typedef logic signed [TOTAL_W-1:0]  total_type;

   typedef struct packed {
      sample_type temp_low;
      sample_type temp_high;
      hum_type    hum_low;
      hum_type    hum_high;
   } limits_type;

   typedef struct packed {
      sample_type avg;
      logic       alarm;
   } lane_res_type;

   function automatic sample_type sat_temp(input sample_type v);
      sample_type r;
      if (v < sample_type'(TEMP_MIN)) begin
         r = sample_type'(TEMP_MIN);
      end else if (v > sample_type'(TEMP_MAX)) begin
         r = sample_type'(TEMP_MAX);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic sample_type sat_hum(input hum_type v);
      sample_type r;
      if (v > hum_type'(HUM_MAX)) begin
         r = sample_type'(HUM_MAX);
      end else begin
         r = sample_type'({1'b0, v});
      end
      return r;
   endfunction

endpackage

// ===== hdl/dual_moving_average_window_alarm_top.sv =====
// Top level of the dual moving-average window alarm: saturation, two lanes,
// response stage and limit registers. Depends on dmawa_pkg and all hdl modules.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  temp_sample, hum_sample
//   rsp      out        rsp_valid/rsp_stall  averages, alarms
//   csr      in         psel/penable/pwrite  paddr, pwdata, prdata
//
// One request per cycle sustained while rsp_stall stays low. An accepted request
// updates the window and total; the divide-and-compare result is then loaded into
// the output register when the response stage advances, and rsp_valid rises with it.
// The running-total add is the loop that sets the request rate.
// Reset clears windows, totals and limits all at once; no sweep.
// req_stall rises only when the response register is stalled and the total
// stage already holds a request.
module dual_moving_average_window_alarm_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  dmawa_pkg::sample_type         req_temp_sample,
   input  dmawa_pkg::hum_type            req_hum_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output dmawa_pkg::sample_type         rsp_temp_average,
   output dmawa_pkg::hum_type            rsp_hum_average,
   output logic                          rsp_temp_alarm,
   output logic                          rsp_hum_alarm,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [dmawa_pkg::ADDR_W-1:0]  paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import dmawa_pkg::*;

   limits_type   limits;
   lane_res_type temp_res, hum_res;
   logic         accept, advance;
   logic         s1_vld_ff, s1_vld_in;
   sample_type   temp_sat, hum_sat;

   assign req_stall = s1_vld_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign s1_vld_in = accept || (s1_vld_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   assign temp_sat = sat_temp(req_temp_sample);
   assign hum_sat  = sat_hum(req_hum_sample);

   dmawa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .limits  (limits)
   );

   dmawa_lane u_temp_lane (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .sample     (temp_sat),
      .low_limit  (limits.temp_low),
      .high_limit (limits.temp_high),
      .result     (temp_res)
   );

   dmawa_lane u_hum_lane (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .sample     (hum_sat),
      .low_limit  (sample_type'({1'b0, limits.hum_low})),
      .high_limit (sample_type'({1'b0, limits.hum_high})),
      .result     (hum_res)
   );

   dmawa_merge u_merge (
      .clock            (clock),
      .reset            (reset),
      .s1_valid         (s1_vld_ff),
      .temp_res         (temp_res),
      .hum_res          (hum_res),
      .rsp_stall        (rsp_stall),
      .advance          (advance),
      .rsp_valid        (rsp_valid),
      .rsp_temp_average (rsp_temp_average),
      .rsp_hum_average  (rsp_hum_average),
      .rsp_temp_alarm   (rsp_temp_alarm),
      .rsp_hum_alarm    (rsp_hum_alarm)
   );

`ifndef SYNTHESIS
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_vld_ff)
      else $error("accepted request did not reach the total stage");
   a_s1_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && advance) |=> rsp_valid)
      else $error("total stage moved but no response appeared");
`endif

endmodule

// ===== hdl/dmawa_csr.sv =====
// Limit registers behind the APB-style port.
// Depends on dmawa_pkg for register indexes, reset values and limits_type.
module dmawa_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [dmawa_pkg::ADDR_W-1:0]   paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready,
   output dmawa_pkg::limits_type          limits
);
   import dmawa_pkg::*;

   limits_type limits_ff, limits_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];
   assign limits  = limits_ff;

   always_comb begin
      limits_in = limits_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_TEMP_LOW:  limits_in.temp_low  = pwdata[14:0];
            REG_TEMP_HIGH: limits_in.temp_high = pwdata[14:0];
            REG_HUM_LOW:   limits_in.hum_low   = pwdata[13:0];
            REG_HUM_HIGH:  limits_in.hum_high  = pwdata[13:0];
            default:       limits_in = limits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.temp_low  <= sample_type'(TEMP_LOW_RESET);
         limits_ff.temp_high <= sample_type'(TEMP_HIGH_RESET);
         limits_ff.hum_low   <= hum_type'(HUM_LOW_RESET);
         limits_ff.hum_high  <= hum_type'(HUM_HIGH_RESET);
      end else begin
         limits_ff <= limits_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_TEMP_LOW:  prdata = 32'(signed'(limits_ff.temp_low));
         REG_TEMP_HIGH: prdata = 32'(signed'(limits_ff.temp_high));
         REG_HUM_LOW:   prdata = {18'd0, limits_ff.hum_low};
         REG_HUM_HIGH:  prdata = {18'd0, limits_ff.hum_high};
         default:       prdata = 32'd0;
      endcase
   end

endmodule

// ===== hdl/dmawa_lane.sv =====
// One averaging lane: ring window, running total, divide by the window
// length and window compare. Depends on dmawa_pkg.
module dmawa_lane (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  dmawa_pkg::sample_type   sample,
   input  dmawa_pkg::sample_type   low_limit,
   input  dmawa_pkg::sample_type   high_limit,
   output dmawa_pkg::lane_res_type result
);
   import dmawa_pkg::*;

   sample_type          window_ff [WINDOW_LENGTH];
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   total_type           total_ff, total_in;
   logic                neg;
   logic [MAG_W-1:0]    mag;
   logic [PROD_W-1:0]   prod;
   logic [MAG_W-1:0]    quot;
   sample_type          avg;

   // Oldest entry leaves the total as the new sample enters it.
   assign total_in = total_ff - total_type'(window_ff[slot_ff]) + total_type'(sample);
   assign slot_in  = (slot_ff == SLOT_W'(WINDOW_LENGTH - 1)) ? '0 : slot_ff + SLOT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         total_ff <= '0;
         for (int i = 0; i < WINDOW_LENGTH; i++) begin
            window_ff[i] <= '0;
         end
      end else if (accept) begin
         slot_ff            <= slot_in;
         total_ff           <= total_in;
         window_ff[slot_ff] <= sample;
      end
   end

   // Truncation toward zero: divide the magnitude, then restore the sign.
   assign neg  = total_ff[TOTAL_W-1];
   assign mag  = neg ? MAG_W'(-total_ff) : MAG_W'(total_ff);
   assign prod = PROD_W'(mag) * PROD_W'(RECIP);
   assign quot = MAG_W'(prod >> SHIFT);
   assign avg  = neg ? -sample_type'(quot) : sample_type'(quot);

   assign result.avg   = avg;
   assign result.alarm = (avg < low_limit) || (avg > high_limit);

`ifndef SYNTHESIS
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_W'(WINDOW_LENGTH - 1))
      else $error("write slot past end of window");
   a_total_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(total_ff))
      else $error("running total moved without a request");
`endif

endmodule

// ===== hdl/dmawa_merge.sv =====
// Output stage: joins the two lane results into one response register.
// Depends on dmawa_pkg for lane_res_type.
module dmawa_merge (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    s1_valid,
   input  dmawa_pkg::lane_res_type temp_res,
   input  dmawa_pkg::lane_res_type hum_res,
   input  logic                    rsp_stall,
   output logic                    advance,
   output logic                    rsp_valid,
   output dmawa_pkg::sample_type   rsp_temp_average,
   output dmawa_pkg::hum_type      rsp_hum_average,
   output logic                    rsp_temp_alarm,
   output logic                    rsp_hum_alarm
);
   import dmawa_pkg::*;

   logic         rsp_valid_ff;
   lane_res_type temp_ff, hum_ff;

   assign advance = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid) begin
         temp_ff <= temp_res;
         hum_ff  <= hum_res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_temp_average = temp_ff.avg;
   assign rsp_hum_average  = hum_ff.avg[13:0];
   assign rsp_temp_alarm   = temp_ff.alarm;
   assign rsp_hum_alarm    = hum_ff.alarm;

endmodule

// ===== tb/window_average_checker.sv =====
// Checker for the dual moving-average window alarm: follows the request and
// response channels and the limit writes, predicts each response and compares.
// Depends on dmawa_pkg for the field types, limits and register codes.
module window_average_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  dmawa_pkg::sample_type        req_temp_sample,
   input  dmawa_pkg::hum_type           req_hum_sample,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  dmawa_pkg::sample_type        rsp_temp_average,
   input  dmawa_pkg::hum_type           rsp_hum_average,
   input  logic                         rsp_temp_alarm,
   input  logic                         rsp_hum_alarm,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [dmawa_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                  pwdata,
   input  logic                         pready,
   output int                           failures,
   output int                           pending_results
);
   import dmawa_pkg::*;

   typedef struct {
      sample_type temp_avg;
      hum_type    hum_avg;
      logic       temp_alarm;
      logic       hum_alarm;
   } window_result_type;

   int temp_low_lim, temp_high_lim, hum_low_lim, hum_high_lim;
   int temp_hist [WINDOW_LENGTH];
   int hum_hist [WINDOW_LENGTH];
   int next_slot;
   int temp_sum, hum_sum;
   int error_tally;
   window_result_type expected_averages[$];

   function automatic window_result_type predict_averages(input sample_type t_in,
                                                          input hum_type h_in);
      int t, h, tavg, havg;
      window_result_type r;
      t = t_in;
      h = h_in;
      if (t < TEMP_MIN) begin
         t = TEMP_MIN;
      end else if (t > TEMP_MAX) begin
         t = TEMP_MAX;
      end
      if (h > HUM_MAX) begin
         h = HUM_MAX;
      end
      temp_sum = temp_sum - temp_hist[next_slot] + t;
      hum_sum  = hum_sum - hum_hist[next_slot] + h;
      temp_hist[next_slot] = t;
      hum_hist[next_slot]  = h;
      next_slot = (next_slot + 1) % WINDOW_LENGTH;
      // int division truncates toward zero, as the block does
      tavg = temp_sum / WINDOW_LENGTH;
      havg = hum_sum / WINDOW_LENGTH;
      r.temp_avg   = sample_type'(tavg);
      r.hum_avg    = hum_type'(havg);
      r.temp_alarm = (tavg < temp_low_lim) || (tavg > temp_high_lim);
      r.hum_alarm  = (havg < hum_low_lim) || (havg > hum_high_lim);
      return r;
   endfunction

   always @(posedge clock) begin
      window_result_type want;
      if (reset) begin
         temp_low_lim  = TEMP_LOW_RESET;
         temp_high_lim = TEMP_HIGH_RESET;
         hum_low_lim   = HUM_LOW_RESET;
         hum_high_lim  = HUM_HIGH_RESET;
         for (int i = 0; i < WINDOW_LENGTH; i++) begin
            temp_hist[i] = 0;
            hum_hist[i]  = 0;
         end
         next_slot = 0;
         temp_sum  = 0;
         hum_sum   = 0;
         expected_averages.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_TEMP_LOW:  temp_low_lim  = $signed(pwdata[14:0]);
               REG_TEMP_HIGH: temp_high_lim = $signed(pwdata[14:0]);
               REG_HUM_LOW:   hum_low_lim   = pwdata[13:0];
               REG_HUM_HIGH:  hum_high_lim  = pwdata[13:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_averages.push_back(predict_averages(req_temp_sample, req_hum_sample));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_averages.size() == 0) begin
               error_tally++;
               if (error_tally <= 10) begin
                  $display("unexpected response: temp_avg=%0d hum_avg=%0d alarms=%b%b",
                           rsp_temp_average, rsp_hum_average, rsp_temp_alarm,
                           rsp_hum_alarm);
               end
            end else begin
               want = expected_averages.pop_front();
               if (rsp_temp_average !== want.temp_avg || rsp_hum_average !== want.hum_avg
                   || rsp_temp_alarm !== want.temp_alarm
                   || rsp_hum_alarm !== want.hum_alarm) begin
                  error_tally++;
                  if (error_tally <= 10) begin
                     $display("mismatch: temp_avg %0d/%0d hum_avg %0d/%0d", want.temp_avg,
                              rsp_temp_average, want.hum_avg, rsp_hum_average);
                     $display("          temp_alarm %b/%b hum_alarm %b/%b (expected/actual)",
                              want.temp_alarm, rsp_temp_alarm, want.hum_alarm,
                              rsp_hum_alarm);
                  end
               end
            end
         end
      end
      failures        <= error_tally;
      pending_results <= expected_averages.size();
   end

   initial begin
      error_tally = 0;
   end

endmodule

// ===== tb/dual_moving_average_window_alarm_top_tb.sv =====
// Testbench top for the dual moving-average window alarm: clock, reset,
// request and limit stimulus, response stalls and the verdict.
// Depends on dmawa_pkg, the block's top level and window_average_checker.
module dual_moving_average_window_alarm_top_tb;
   import dmawa_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   sample_type        req_temp_sample = '0;
   hum_type           req_hum_sample = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   sample_type        rsp_temp_average;
   hum_type           rsp_hum_average;
   logic              rsp_temp_alarm;
   logic              rsp_hum_alarm;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   int failures;
   int pending_results;
   int cycle_count = 0;
   int sent_total = 0;
   bit idle_on = 1'b1;

   dual_moving_average_window_alarm_top DUT (.*);

   window_average_checker averages_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("dual_moving_average_window_alarm_top_tb NOT OK");
         $finish;
      end
   end

   // Response side: short random stalls, plus two long hold-offs mid-run so
   // the pipeline fills and the block pushes back on requests.
   initial begin
      int hold_step;
      hold_step = 0;
      wait (!reset);
      forever begin
         if (hold_step < 2 && sent_total >= (hold_step == 0 ? 150 : 480)) begin
            rsp_stall <= 1'b1;
            repeat (40) @(posedge clock);
            hold_step++;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   task automatic push_request(input sample_type t, input hum_type h);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_temp_sample <= t;
      req_hum_sample  <= h;
      do @(posedge clock); while (req_stall);
      sent_total++;
   endtask

   // Limits may only change with nothing in flight.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Leaves the bus selected; the caller releases it after the last write.
   task automatic csr_write(input logic [1:0] idx, input int val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   task automatic set_limits(input int t_lo, input int t_hi, input int h_lo, input int h_hi);
      drain();
      csr_write(REG_TEMP_LOW, t_lo);
      csr_write(REG_TEMP_HIGH, t_hi);
      csr_write(REG_HUM_LOW, h_lo);
      csr_write(REG_HUM_HIGH, h_hi);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   function automatic sample_type pick_temp(input int center);
      int v;
      case ($urandom_range(0, 9))
         0: v = int'($urandom_range(0, 32767)) - 16384;
         1: v = $urandom_range(0, 1) ? TEMP_MAX : TEMP_MIN;
         default: begin
            v = center + int'($urandom_range(0, 1200)) - 600;
            if (v < TEMP_MIN) v = TEMP_MIN;
            if (v > TEMP_MAX) v = TEMP_MAX;
         end
      endcase
      return sample_type'(v);
   endfunction

   function automatic hum_type pick_hum(input int center);
      int v;
      case ($urandom_range(0, 9))
         0: v = $urandom_range(0, 16383);
         1: v = $urandom_range(0, 1) ? HUM_MAX : 0;
         default: begin
            v = center + int'($urandom_range(0, 1600)) - 800;
            if (v < 0) v = 0;
            if (v > HUM_MAX) v = HUM_MAX;
         end
      endcase
      return hum_type'(v);
   endfunction

   initial begin
      sample_type dir_temp[11];
      hum_type    dir_hum[11];
      int temp_center, hum_center, lo, k;

      // field extremes and saturation edges; the first request checks that a
      // negative total divides toward zero
      dir_temp = '{-15, -16384, -4001, -4000, 8500, 8501, 16383, 0, -1, 10922, -10923};
      dir_hum  = '{5, 0, 16383, 10000, 10001, 9999, 1, 0, 8191, 10922, 5461};

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset limits, window still partly empty
      for (k = 0; k < 11; k++) push_request(dir_temp[k], dir_hum[k]);
      for (k = 0; k < 10; k++) push_request(2400, 4500);
      push_request(2200, 3000);

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: set_limits(-16384, 16383, 0, 16383);
            1: set_limits(16383, -16384, 16383, 0);   // low above high: always alarm
            2: set_limits(2500, 2500, 5000, 5000);
            3: set_limits(TEMP_MIN, TEMP_MAX, 0, HUM_MAX);
            default: begin
               lo = int'($urandom_range(0, 10500)) - 4000;
               k  = $urandom_range(0, 8000);
               set_limits(lo, lo + int'($urandom_range(0, 2000)), k,
                          k + int'($urandom_range(0, 2000)));
            end
         endcase
         idle_on = (p != 2 && p != 5);
         for (k = 0; k < 120; k++) begin
            if (k % 10 == 0) begin
               temp_center = int'($urandom_range(0, 12500)) - 4000;
               hum_center  = $urandom_range(0, 10000);
            end
            push_request(pick_temp(temp_center), pick_hum(hum_center));
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("dual_moving_average_window_alarm_top_tb OK");
      end else begin
         $display("dual_moving_average_window_alarm_top_tb NOT OK");
      end
      $finish;
   end

endmodule
